### rtl/utt_pkg.sv
package utt_pkg;

   // output queue depth; at least two so the mark and a character fit together
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [15:0] BOM_UNIT       = 16'hFEFF;
   localparam logic        ORDER_LITTLE   = 1'b0;
   localparam logic        ORDER_BIG      = 1'b1;

   localparam logic [1:0]  PEND_NONE      = 2'd0;
   localparam logic [1:0]  PEND_ONE       = 2'd1;
   localparam logic [1:0]  PEND_TWO       = 2'd2;

   localparam logic [1:0]  PUSH_NONE      = 2'd0;
   localparam logic [1:0]  PUSH_ONE       = 2'd1;
   localparam logic [1:0]  PUSH_TWO       = 2'd2;

   typedef struct packed {
      logic [1:0]  pending_count;
      logic [15:0] partial_value;
      logic        mark_sent;
   } dec_state_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       is_bom;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type entry0;
      result_type entry1;
   } push_type;

endpackage

### rtl/utf8_to_utf16_transcoder_unit.sv
// utf-8 to utf-16 transcoder, one byte per request
//
// request channel: req_valid / req_ready carry one raw utf-8 byte (req_in_byte).
// response channel: rsp_valid / rsp_ready carry one 16-bit unit as two bytes in
// file order, plus rsp_is_bom for the byte order mark and rsp_last on the final
// unit caused by a request. config: csr_wr_en / csr_wr_data set the byte order
// (0 little-endian, 1 big-endian); write it only while the block is idle.
//
// a unit is registered in the response queue when its request is taken.
// throughput: one request per cycle while req_ready is high. decode is a single pass
// of short logic from the decoder state into a response queue, 4 entries by default.
// the very first request after reset produces the mark and possibly a character, so
// the queue may drain two units for it; req_ready is high while two more fit.
//
// reset: clears the sequence state, the mark-sent flag and the byte order, and
// empties the response queue. when the receiver stalls, units wait in the queue
// and requests keep being taken until it is nearly full.
module utf8_to_utf16_transcoder_unit #(
   parameter int unsigned QUEUE_DEPTH = utt_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_first_byte,
   output logic [7:0] rsp_second_byte,
   output logic       rsp_is_bom,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import utt_pkg::*;

   dec_state_type state_cur;
   dec_state_type state_nxt;
   push_type      push;
   result_type    head;
   logic          byte_order;
   logic          room_two;
   logic          req_fire;

   // a request is taken only when both of its possible units fit
   assign req_ready = room_two;
   assign req_fire  = req_valid && req_ready;

   // sequence state and byte order register
   utt_state_reg u_state (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .state_nxt   (state_nxt),
      .state_cur   (state_cur),
      .byte_order  (byte_order)
   );

   // single-pass decode of the incoming byte
   utt_decode u_decode (
      .req_fire   (req_fire),
      .in_byte    (req_in_byte),
      .byte_order (byte_order),
      .state_cur  (state_cur),
      .state_nxt  (state_nxt),
      .push       (push)
   );

   // response queue decouples the decoder from receiver stalls
   utt_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room_two   (room_two),
      .head_valid (rsp_valid),
      .head_pop   (rsp_ready),
      .head       (head)
   );

   assign rsp_first_byte  = head.first_byte;
   assign rsp_second_byte = head.second_byte;
   assign rsp_is_bom      = head.is_bom;
   assign rsp_last        = head.last;

endmodule

### rtl/utt_decode.sv
module utt_decode (
   input  logic                  req_fire,
   input  logic [7:0]            in_byte,
   input  logic                  byte_order,
   input  utt_pkg::dec_state_type state_cur,
   output utt_pkg::dec_state_type state_nxt,
   output utt_pkg::push_type      push
);
   import utt_pkg::*;

   logic        char_valid;
   logic [15:0] char_unit;
   logic [15:0] cont_sum;
   logic        bom_due;

   function automatic result_type make_result(input logic [15:0] unit, input logic bom,
                                              input logic is_last, input logic order);
      result_type r;
      if (order == ORDER_BIG) begin
         r.first_byte  = unit[15:8];
         r.second_byte = unit[7:0];
      end else begin
         r.first_byte  = unit[7:0];
         r.second_byte = unit[15:8];
      end
      r.is_bom = bom;
      r.last   = is_last;
      return r;
   endfunction

   assign cont_sum = state_cur.partial_value + {10'b0, in_byte[5:0]};
   assign bom_due  = !state_cur.mark_sent;

   always_comb begin
      state_nxt           = state_cur;
      state_nxt.mark_sent = 1'b1;
      char_valid          = 1'b0;
      char_unit           = {8'b0, in_byte};
      if (state_cur.pending_count == PEND_NONE) begin
         case (in_byte) inside
            8'b0???????: begin
               char_valid = 1'b1;
            end
            8'b110?????: begin
               state_nxt.partial_value = {5'b0, in_byte[4:0], 6'b0};
               state_nxt.pending_count = PEND_ONE;
            end
            8'b111?????: begin
               state_nxt.partial_value = {6'b0, in_byte[3:0], 6'b0};
               state_nxt.pending_count = PEND_TWO;
            end
            default: begin
               // stray continuation byte, dropped
            end
         endcase
      end else if (in_byte[7:6] == 2'b10) begin
         if (state_cur.pending_count == PEND_TWO) begin
            state_nxt.pending_count = PEND_ONE;
            state_nxt.partial_value = {cont_sum[9:0], 6'b0};
         end else begin
            char_valid              = 1'b1;
            char_unit               = cont_sum;
            state_nxt.pending_count = PEND_NONE;
            state_nxt.partial_value = 16'b0;
         end
      end else begin
         // bad continuation: sequence dropped, byte consumed
         state_nxt.pending_count = PEND_NONE;
         state_nxt.partial_value = 16'b0;
      end
   end

   always_comb begin
      push.count  = PUSH_NONE;
      push.entry0 = make_result(BOM_UNIT, 1'b1, !char_valid, byte_order);
      push.entry1 = make_result(char_unit, 1'b0, 1'b1, byte_order);
      if (!bom_due) begin
         push.entry0 = make_result(char_unit, 1'b0, 1'b1, byte_order);
      end
      if (req_fire) begin
         if (bom_due && char_valid) begin
            push.count = PUSH_TWO;
         end else if (bom_due || char_valid) begin
            push.count = PUSH_ONE;
         end
      end
   end

endmodule

### rtl/utt_rsp_queue.sv
module utt_rsp_queue #(
   parameter int unsigned DEPTH = utt_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  utt_pkg::push_type  push,
   output logic               room_two,
   output logic               head_valid,
   input  logic               head_pop,
   output utt_pkg::result_type head
);
   import utt_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]     wr_ptr_p1, wr_ptr_p2;
   logic                 pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr_p1  = ptr_inc(wr_ptr_ff);
   assign wr_ptr_p2  = ptr_inc(wr_ptr_p1);
   assign head_valid = (count_ff != '0);
   assign pop        = head_valid && head_pop;
   assign head       = entry_ff[rd_ptr_ff];
   assign room_two   = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == PUSH_ONE) begin
         wr_ptr_in = wr_ptr_p1;
      end else if (push.count == PUSH_TWO) begin
         wr_ptr_in = wr_ptr_p2;
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != PUSH_NONE) begin
         entry_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.count == PUSH_TWO) begin
         entry_ff[wr_ptr_p1] <= push.entry1;
      end
   end

endmodule

### rtl/utt_to_utf16_top_placeholder.sv
module utt_state_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  utt_pkg::dec_state_type state_nxt,
   output utt_pkg::dec_state_type state_cur,
   output logic                   byte_order
);
   import utt_pkg::*;

   dec_state_type state_ff;
   logic          order_ff;

   assign state_cur  = state_ff;
   assign byte_order = order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         order_ff <= ORDER_LITTLE;
      end else begin
         if (req_fire) begin
            state_ff <= state_nxt;
         end
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
      end
   end

endmodule

### tb/tb_utf8_to_utf16_transcoder_unit.sv
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder_unit;
   import utt_pkg::*;

   // receiver hold-off length in cycles, long enough to fill the response queue
   localparam int HOLD_CYCLES  = 80;
   // settle time after the last response before a csr write or the verdict
   localparam int SETTLE_CYCLES = 8;
   // requests per random phase
   localparam int PHASE_BYTES  = 75;
   localparam int NUM_PHASES   = 6;
   // percent of cycles each side idles
   localparam int IDLE_PCT     = 24;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_first_byte;
   logic [7:0] rsp_second_byte;
   logic       rsp_is_bom;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   utf8_to_utf16_transcoder_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_first_byte (rsp_first_byte),
      .rsp_second_byte(rsp_second_byte),
      .rsp_is_bom     (rsp_is_bom),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #1 clock = ~clock;

   // bytes waiting to be offered, and the units the decoder should produce
   logic [7:0] pending_bytes[$];
   result_type expected_units[$];
   int         bytes_queued = 0;   // written only by the stimulus process
   int         bytes_taken  = 0;   // written only by the monitor
   int         errors       = 0;

   // flags from the stimulus process, changed only at rising edges
   logic       calm = 1'b0;        // no idling on either side
   int         hold_asked = 0;     // bumped to ask the receiver for a hold-off

   logic       req_fire = 1'b0;    // request taken at the last rising edge

   // decoder mirror: byte order, continuation bytes still owed, code value so far,
   // and whether the byte order mark has gone out
   logic       model_order = ORDER_LITTLE;
   logic [1:0] seq_left    = PEND_NONE;
   logic [15:0] code_acc   = 16'h0000;
   logic       mark_done   = 1'b0;

   // place one 16-bit unit into file order under the current byte order
   function automatic result_type make_unit(logic [15:0] unit, logic bom);
      result_type r;
      if (model_order == ORDER_BIG) begin
         r.first_byte  = unit[15:8];
         r.second_byte = unit[7:0];
      end else begin
         r.first_byte  = unit[7:0];
         r.second_byte = unit[15:8];
      end
      r.is_bom = bom;
      r.last   = 1'b0;
      return r;
   endfunction

   // advance the decoder mirror by one byte and queue what it emits
   task automatic decode_byte(input logic [7:0] b);
      result_type units[$];
      // the mark precedes whatever the first byte after reset produces
      if (!mark_done) begin
         units.push_back(make_unit(BOM_UNIT, 1'b1));
         mark_done = 1'b1;
      end
      if (seq_left == PEND_NONE) begin
         if (b[7] == 1'b0) begin
            units.push_back(make_unit({8'h00, b}, 1'b0));
         end else if (b[7:5] == 3'b110) begin
            code_acc = {5'b0, b[4:0], 6'b0};
            seq_left = PEND_ONE;
         end else if (b[7:5] == 3'b111) begin
            // 0xf0..0xff fall in here too and keep only their low four bits
            code_acc = {6'b0, b[3:0], 6'b0};
            seq_left = PEND_TWO;
         end
         // stray continuation byte: nothing
      end else if (b[7:6] == 2'b10) begin
         code_acc = code_acc + {10'b0, b[5:0]};
         if (seq_left == PEND_TWO) begin
            seq_left = PEND_ONE;
            code_acc = code_acc << 6;
         end else begin
            units.push_back(make_unit(code_acc, 1'b0));
            seq_left = PEND_NONE;
            code_acc = 16'h0000;
         end
      end else begin
         // bad continuation: sequence dropped, byte swallowed
         seq_left = PEND_NONE;
         code_acc = 16'h0000;
      end
      if (units.size() != 0) units[units.size() - 1].last = 1'b1;
      foreach (units[i]) expected_units.push_back(units[i]);
   endtask

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // driver: a new request is picked only once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_in_byte <= pending_bytes.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off counted here when asked
   int hold_seen = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // monitor: predict on each taken request, then check each taken response
   always @(posedge clock) begin : monitor_blk
      result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            decode_byte(req_in_byte);
            bytes_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h %0h bom %0b last %0b",
                        $time, rsp_first_byte, rsp_second_byte, rsp_is_bom, rsp_last);
               errors++;
            end else begin
               want = expected_units.pop_front();
               compare_field("first_byte", int'(want.first_byte), int'(rsp_first_byte));
               compare_field("second_byte", int'(want.second_byte), int'(rsp_second_byte));
               compare_field("is_bom", int'(want.is_bom), int'(rsp_is_bom));
               compare_field("last", int'(want.last), int'(rsp_last));
            end
         end
      end
   end

   // stimulus helpers, called at falling edges only
   task automatic add_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // one character worth of bytes: mostly well-formed, some noise and broken runs
   task automatic add_random_char();
      int pick;
      logic [7:0] r;
      pick = $urandom_range(0, 99);
      r = 8'($urandom_range(0, 255));
      if (pick < 35) begin
         add_byte({1'b0, r[6:0]});
      end else if (pick < 60) begin
         add_byte({3'b110, r[4:0]});
         add_byte({2'b10, 6'($urandom_range(0, 63))});
      end else if (pick < 85) begin
         // lead 0xe0..0xff, so the four-byte leads are covered as well
         add_byte({3'b111, r[4:0]});
         add_byte({2'b10, 6'($urandom_range(0, 63))});
         add_byte({2'b10, 6'($urandom_range(0, 63))});
      end else if (pick < 92) begin
         add_byte(r);
      end else begin
         // lead followed by an arbitrary byte that may or may not continue it
         add_byte(r[0] ? {3'b110, r[5:1]} : {3'b111, r[5:1]});
         add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // returns at a falling edge once every request was taken and answered
   task automatic wait_drained();
      while (!(bytes_taken == bytes_queued && expected_units.size() == 0))
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_order(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      model_order = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus_blk
      logic [7:0] directed[] = '{
         8'h00, 8'h7F, 8'h41,             // ascii extremes
         8'hC2, 8'h80, 8'hDF, 8'hBF,      // two-byte, low and high
         8'hE0, 8'h80, 8'h80,             // three-byte, all zero payload
         8'hEF, 8'hBF, 8'hBF,             // three-byte, all ones payload
         8'h80, 8'hBF,                    // stray continuations
         8'hC3, 8'h41,                    // bad continuation after a two-byte lead
         8'hE2, 8'h82, 8'hC0,             // bad continuation mid three-byte
         8'hF0, 8'h9F, 8'h98,             // four-byte lead taken as three-byte
         8'hFF, 8'hBF, 8'hBF,
         8'hE2, 8'h82                     // left unfinished across the csr write
      };
      int n;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // order before the first request decides how the mark goes out
      write_order(1'($urandom_range(0, 1)));

      foreach (directed[i]) add_byte(directed[i]);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // extremes first, then random settings
         case (ph)
            0, 2: begin
               write_order(ORDER_BIG);
            end
            1, 3: begin
               write_order(ORDER_LITTLE);
            end
            default: begin
               write_order(1'($urandom_range(0, 1)));
            end
         endcase
         n = bytes_queued;
         while (bytes_queued - n < PHASE_BYTES) add_random_char();
         if (ph == 2) begin
            @(posedge clock);
            calm = 1'b1;
         end
         if (ph == 4) begin
            // receiver holds off while the sender keeps offering
            repeat (5) @(posedge clock);
            hold_asked++;
         end
         // sender pauses here until every response is in
         @(negedge clock);
         wait_drained();
         if (ph == 2) begin
            @(posedge clock);
            calm = 1'b0;
            @(negedge clock);
         end
      end

      if (errors == 0) begin
         $display("** utf8_to_utf16_transcoder_unit: PASSED **");
      end else begin
         $display("** utf8_to_utf16_transcoder_unit: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #400000;
      $display("** utf8_to_utf16_transcoder_unit: FAILED **");
      $finish;
   end

endmodule
